FILE: sv/tsd_pkg.sv
// Package for the keypad tone symbol SECDED decoder.
// Holds the field widths, block geometry and the symbol-to-nibble map.
// No dependencies.
package tsd_pkg;

   localparam int SymbolWidth    = 8;
   localparam int NibbleWidth    = 4;
   localparam int RowCount       = 4;
   localparam int RowIndexWidth  = 2;
   localparam int CountWidth     = 3;
   localparam int DirectionWidth = 3;

   // Count value that stands for "more than four nibbles".
   localparam logic [CountWidth-1:0] CountSaturated = 3'd5;
   localparam logic [CountWidth-1:0] CountFull      = 3'd4;

   // Command reported when the stop bit is set.
   localparam logic [DirectionWidth-1:0] CommandStop = 3'd1;
   localparam logic [DirectionWidth-1:0] CommandNone = 3'd0;

   // Column mask for column code zero; the other codes shift it right.
   localparam logic [NibbleWidth-1:0] ColumnMaskBase = 4'b1000;

   typedef struct packed {
      logic                   valid;
      logic [NibbleWidth-1:0] nibble;
   } symbol_map_type;

   // Maps a tone character to its nibble; any other character is not valid.
   function automatic symbol_map_type map_symbol(input logic [SymbolWidth-1:0] symbol);
      symbol_map_type result;
      result.valid = 1'b1;
      case (symbol)
         8'h31:   result.nibble = 4'd0;   // '1'
         8'h32:   result.nibble = 4'd1;   // '2'
         8'h33:   result.nibble = 4'd2;   // '3'
         8'h61:   result.nibble = 4'd3;   // 'a'
         8'h34:   result.nibble = 4'd4;   // '4'
         8'h35:   result.nibble = 4'd5;   // '5'
         8'h36:   result.nibble = 4'd6;   // '6'
         8'h62:   result.nibble = 4'd7;   // 'b'
         8'h37:   result.nibble = 4'd8;   // '7'
         8'h38:   result.nibble = 4'd9;   // '8'
         8'h39:   result.nibble = 4'd10;  // '9'
         8'h63:   result.nibble = 4'd11;  // 'c'
         8'h2a:   result.nibble = 4'd12;  // '*'
         8'h30:   result.nibble = 4'd13;  // '0'
         8'h23:   result.nibble = 4'd14;  // '#'
         8'h64:   result.nibble = 4'd15;  // 'd'
         default: begin
            result.valid  = 1'b0;
            result.nibble = 4'd0;
         end
      endcase
      return result;
   endfunction

endpackage

FILE: sv/tone_symbol_secded_decoder_top.sv
// Top level of the keypad tone symbol SECDED decoder.
// Collects four nibbles, decodes the extended Hamming (16,11) block on the last symbol.
// Depends on tsd_pkg.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_symbol[7:0], req_last
//   rsp_      out         rsp_valid/rsp_ready    rsp_code_ok, rsp_corrected, rsp_stop_flag,
//                                                rsp_direction[2:0], rsp_command[2:0]
//
// One symbol is accepted per cycle while req_ready is high; the decode of a
// symbol with req_last is registered and shows on the rsp_ channel in the next cycle.
// A single output register holds the result; req_ready drops only while that
// register is full and rsp_ready is low.
// Synchronous active-high reset clears the nibble count and the output valid.
module tone_symbol_secded_decoder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tsd_pkg::SymbolWidth-1:0]    req_symbol,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_code_ok,
   output logic                               rsp_corrected,
   output logic                               rsp_stop_flag,
   output logic [tsd_pkg::DirectionWidth-1:0] rsp_direction,
   output logic [tsd_pkg::DirectionWidth-1:0] rsp_command
);

   logic [tsd_pkg::NibbleWidth-1:0] store_ff [tsd_pkg::RowCount];
   logic [tsd_pkg::NibbleWidth-1:0] store_in [tsd_pkg::RowCount];
   logic [tsd_pkg::CountWidth-1:0]  count_ff, count_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               code_ok_ff, code_ok_in;
   logic                               corrected_ff, corrected_in;
   logic                               stop_ff, stop_in;
   logic [tsd_pkg::DirectionWidth-1:0] direction_ff, direction_in;
   logic [tsd_pkg::DirectionWidth-1:0] command_ff, command_in;

   tsd_pkg::symbol_map_type mapped;
   logic                    accept;

   logic [tsd_pkg::NibbleWidth-1:0]   fixed [tsd_pkg::RowCount];
   logic                              p1, p2, p3, p4, pt, syndrome;
   logic [tsd_pkg::RowIndexWidth-1:0] err_row, err_col;
   logic                              block_ok;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign mapped    = tsd_pkg::map_symbol(req_symbol);

   // Store and count after this symbol; the decode sees the nibble it brings.
   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      if (accept && mapped.valid) begin
         if (count_ff < tsd_pkg::CountFull) begin
            store_in[count_ff[tsd_pkg::RowIndexWidth-1:0]] = mapped.nibble;
         end
         if (count_ff < tsd_pkg::CountSaturated) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // Row, column and overall parities of the 4x4 block.
   always_comb begin
      p1 = 1'b0;
      p2 = 1'b0;
      p3 = 1'b0;
      p4 = 1'b0;
      pt = 1'b0;
      for (int r = 0; r < tsd_pkg::RowCount; r++) begin
         p1 = p1 ^ store_in[r][2] ^ store_in[r][0];
         p2 = p2 ^ store_in[r][1] ^ store_in[r][0];
         if (r[0]) begin
            p3 = p3 ^ (^store_in[r]);
         end
         if (r[1]) begin
            p4 = p4 ^ (^store_in[r]);
         end
         pt = pt ^ (^store_in[r]);
      end
      syndrome = p1 | p2 | p3 | p4;
      err_row  = {p4, p3};
      err_col  = {p2, p1};
      fixed    = store_in;
      // An odd overall parity means one flipped bit; a zero syndrome points it
      // at the overall parity bit itself, which is bit 3 of row 0.
      if (pt) begin
         fixed[err_row] = store_in[err_row] ^ (tsd_pkg::ColumnMaskBase >> err_col);
      end
      block_ok = (count_in == tsd_pkg::CountFull) && (pt || !syndrome);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      code_ok_in   = code_ok_ff;
      corrected_in = corrected_ff;
      stop_in      = stop_ff;
      direction_in = direction_ff;
      command_in   = command_ff;
      if (accept && req_last) begin
         rsp_valid_in = 1'b1;
         code_ok_in   = block_ok;
         corrected_in = block_ok && pt;
         stop_in      = block_ok && fixed[0][0];
         direction_in = block_ok ? fixed[1][tsd_pkg::DirectionWidth-1:0] : tsd_pkg::CommandNone;
         if (!block_ok) begin
            command_in = tsd_pkg::CommandNone;
         end else if (fixed[0][0]) begin
            command_in = tsd_pkg::CommandStop;
         end else begin
            command_in = fixed[1][tsd_pkg::DirectionWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= (accept && req_last) ? '0 : count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff     <= store_in;
      code_ok_ff   <= code_ok_in;
      corrected_ff <= corrected_in;
      stop_ff      <= stop_in;
      direction_ff <= direction_in;
      command_ff   <= command_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_ok   = code_ok_ff;
   assign rsp_corrected = corrected_ff;
   assign rsp_stop_flag = stop_ff;
   assign rsp_direction = direction_ff;
   assign rsp_command   = command_ff;

endmodule

FILE: sv/tsd_checker.sv
// Port-level checker for the keypad tone symbol SECDED decoder, bound to the top level.
// Depends on tsd_pkg and tone_symbol_secded_decoder_top.
module tsd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               req_last,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_code_ok,
   input logic                               rsp_corrected,
   input logic                               rsp_stop_flag,
   input logic [tsd_pkg::DirectionWidth-1:0] rsp_direction,
   input logic [tsd_pkg::DirectionWidth-1:0] rsp_command
);

   // A stalled result stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command) && $stable(rsp_code_ok))
      else $error("stalled result changed");

   // A new result appears only after a transfer that carried the last symbol.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last))
      else $error("result without a last symbol");

   // A rejected block reports nothing else.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_code_ok |-> !rsp_corrected && !rsp_stop_flag
         && rsp_direction == tsd_pkg::CommandNone && rsp_command == tsd_pkg::CommandNone)
      else $error("rejected block with nonzero fields");

   // The command follows the stop bit and the direction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_ok |->
         (rsp_stop_flag && rsp_command == tsd_pkg::CommandStop)
         || (!rsp_stop_flag && rsp_command == rsp_direction))
      else $error("command does not match stop and direction");

endmodule

bind tone_symbol_secded_decoder_top tsd_checker u_tsd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_code_ok   (rsp_code_ok),
   .rsp_corrected (rsp_corrected),
   .rsp_stop_flag (rsp_stop_flag),
   .rsp_direction (rsp_direction),
   .rsp_command   (rsp_command)
);
